[rtl/dhs_pkg.sv]
`default_nettype none
package dhs_pkg;

	localparam int SLOTS      = 4093;
	localparam int STEP_PRIME = 1021;
	localparam int KEY_W      = 63;
	localparam int COUNT_W    = 12;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int LIVE_W     = $clog2(SLOTS + 1);
	localparam int STEP_W     = $clog2(STEP_PRIME + 1);
	localparam int REM_W      = $clog2(STEP_PRIME);
	// key bits folded into both remainders per cycle
	localparam int BPC        = 3;
	localparam int MOD_CYC    = (KEY_W + BPC - 1) / BPC;
	localparam int KEY_PAD    = MOD_CYC * BPC;
	localparam int MOD_CNT_W  = $clog2(MOD_CYC + 1);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY_SET = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] h0;
		logic [STEP_W-1:0] step;
	} job_t;

endpackage
`default_nettype wire

[rtl/dhs_if.sv]
`default_nettype none
interface dhs_in_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              op;
	logic [dhs_pkg::KEY_W-1:0] key;
	modport source (output valid, op, key, input ready);
	modport sink (input valid, op, key, output ready);
endinterface

interface dhs_out_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [1:0]                  status;
	logic [dhs_pkg::COUNT_W-1:0] count;
	modport source (output valid, found, status, count, input ready);
	modport sink (input valid, found, status, count, output ready);
endinterface
`default_nettype wire

[rtl/dhs_front.sv]
`default_nettype none
module dhs_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	dhs_in_if.sink            in_ch,
	output dhs_pkg::job_t     job,
	output logic              job_valid,
	input  wire logic         job_ready
);

	logic                            busy_q;
	logic                            job_valid_q;
	dhs_pkg::job_t                   job_q;
	logic [dhs_pkg::KEY_PAD-1:0]     sh_q;
	logic [dhs_pkg::SLOT_W-1:0]      rh_q, rh_n;
	logic [dhs_pkg::REM_W-1:0]       rs_q, rs_n;
	logic [dhs_pkg::MOD_CNT_W-1:0]   cnt_q;
	logic [dhs_pkg::SLOT_W:0]        th;
	logic [dhs_pkg::REM_W:0]         ts;

	assign in_ch.ready = !busy_q && !job_valid_q;
	assign job         = job_q;
	assign job_valid   = job_valid_q;

	// fold BPC key bits, MSB first, into both remainders
	always_comb begin
		rh_n = rh_q;
		rs_n = rs_q;
		th   = '0;
		ts   = '0;
		for (int i = 0; i < dhs_pkg::BPC; i++) begin
			th = {rh_n, sh_q[dhs_pkg::KEY_PAD-1-i]};
			if (th >= (dhs_pkg::SLOT_W+1)'(dhs_pkg::SLOTS))
				th = th - (dhs_pkg::SLOT_W+1)'(dhs_pkg::SLOTS);
			rh_n = th[dhs_pkg::SLOT_W-1:0];
			ts = {rs_n, sh_q[dhs_pkg::KEY_PAD-1-i]};
			if (ts >= (dhs_pkg::REM_W+1)'(dhs_pkg::STEP_PRIME))
				ts = ts - (dhs_pkg::REM_W+1)'(dhs_pkg::STEP_PRIME);
			rs_n = ts[dhs_pkg::REM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			job_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (job_valid_q && job_ready)
				job_valid_q <= 1'b0;
			if (in_ch.valid && in_ch.ready) begin
				busy_q     <= 1'b1;
				cnt_q      <= '0;
				rh_q       <= '0;
				rs_q       <= '0;
				sh_q       <= dhs_pkg::KEY_PAD'(in_ch.key);
				job_q.op   <= dhs_pkg::op_t'(in_ch.op);
				job_q.key  <= in_ch.key;
			end else if (busy_q) begin
				rh_q  <= rh_n;
				rs_q  <= rs_n;
				sh_q  <= sh_q << dhs_pkg::BPC;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dhs_pkg::MOD_CNT_W'(dhs_pkg::MOD_CYC - 1)) begin
					busy_q      <= 1'b0;
					job_valid_q <= 1'b1;
					job_q.h0    <= rh_n;
					job_q.step  <= dhs_pkg::STEP_W'(dhs_pkg::STEP_PRIME)
						- dhs_pkg::STEP_W'(rs_n);
				end
			end
		end
	end

endmodule
`default_nettype wire

[rtl/dhs_queue.sv]
`default_nettype none
module dhs_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dhs_pkg::job_t wr_job,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	output dhs_pkg::job_t      rd_job,
	output logic               rd_valid,
	input  wire logic          rd_ready
);

	dhs_pkg::job_t slot_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    fill_q;
	logic          push, pop;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_job   = slot_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

[rtl/dhs_back.sv]
`default_nettype none
module dhs_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dhs_pkg::job_t job,
	input  wire logic          job_valid,
	output logic               job_ready,
	dhs_out_if.source          out_ch
);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_CHECK, S_WRITE, S_REPLY
	} state_t;

	state_t                        state_q;
	logic [dhs_pkg::SLOT_W-1:0]    clr_q;
	dhs_pkg::op_t                  op_q;
	logic [dhs_pkg::KEY_W-1:0]     key_q;
	logic [dhs_pkg::SLOT_W-1:0]    h_q, hit_q, free_q;
	logic [dhs_pkg::STEP_W-1:0]    step_q;
	logic [dhs_pkg::LIVE_W-1:0]    n_q, live_q;
	logic                          kdone_q, found_q, free_ok_q, limit_q;
	logic                          res_found_q;
	dhs_pkg::status_t              res_status_q;
	logic                          out_valid_q, out_found_q;
	logic [1:0]                    out_status_q;
	logic [dhs_pkg::COUNT_W-1:0]   out_count_q;

	logic [dhs_pkg::KEY_W-1:0]     key_mem [dhs_pkg::SLOTS];
	logic [1:0]                    mark_mem [dhs_pkg::SLOTS];
	logic [dhs_pkg::KEY_W-1:0]     key_rd;
	logic [1:0]                    mark_rd;

	logic                          occ, tomb, live_hit, is_free, kd_n, fok_n, walk_end;
	logic [dhs_pkg::SLOT_W:0]      h_sum;
	logic [dhs_pkg::SLOT_W-1:0]    h_next;
	logic                          key_we, mark_we;
	logic [dhs_pkg::SLOT_W-1:0]    wa;
	logic [1:0]                    wmark;

	assign job_ready     = (state_q == S_IDLE);
	assign out_ch.valid  = out_valid_q;
	assign out_ch.found  = out_found_q;
	assign out_ch.status = out_status_q;
	assign out_ch.count  = out_count_q;

	assign occ      = mark_rd[1];
	assign tomb     = mark_rd[0];
	assign live_hit = occ && !tomb && (key_rd == key_q);
	assign is_free  = !occ || tomb;
	assign kd_n     = kdone_q || !occ || live_hit;
	assign fok_n    = free_ok_q || is_free;
	assign walk_end = (kd_n && (op_q != dhs_pkg::OP_ADD || fok_n))
		|| (n_q == dhs_pkg::LIVE_W'(dhs_pkg::SLOTS - 1));

	// step stays below the table size, so one subtract wraps the sum
	assign h_sum  = {1'b0, h_q} + (dhs_pkg::SLOT_W+1)'(step_q);
	assign h_next = (h_sum >= (dhs_pkg::SLOT_W+1)'(dhs_pkg::SLOTS))
		? dhs_pkg::SLOT_W'(h_sum - (dhs_pkg::SLOT_W+1)'(dhs_pkg::SLOTS))
		: h_sum[dhs_pkg::SLOT_W-1:0];

	always_comb begin
		key_we  = 1'b0;
		mark_we = 1'b0;
		wa      = free_q;
		wmark   = 2'b10;
		case (state_q)
			S_CLEAR: begin
				mark_we = 1'b1;
				wa      = clr_q;
				wmark   = 2'b00;
			end
			S_WRITE: begin
				if (op_q == dhs_pkg::OP_ADD && free_ok_q) begin
					key_we  = 1'b1;
					mark_we = 1'b1;
				end else if (op_q == dhs_pkg::OP_REMOVE && found_q) begin
					mark_we = 1'b1;
					wa      = hit_q;
					wmark   = 2'b11;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[wa] <= key_q;
		key_rd <= key_mem[h_q];
	end

	always_ff @(posedge clk) begin
		if (mark_we)
			mark_mem[wa] <= wmark;
		mark_rd <= mark_mem[h_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_REPLY && (!out_valid_q || out_ch.ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == dhs_pkg::SLOT_W'(dhs_pkg::SLOTS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (job_valid) begin
						op_q         <= job.op;
						key_q        <= job.key;
						h_q          <= job.h0;
						step_q       <= job.step;
						n_q          <= '0;
						kdone_q      <= 1'b0;
						found_q      <= 1'b0;
						free_ok_q    <= 1'b0;
						res_found_q  <= 1'b0;
						res_status_q <= dhs_pkg::ST_OK;
						if (job.op == dhs_pkg::OP_RSVD)
							state_q <= S_REPLY;
						else if (job.op == dhs_pkg::OP_REMOVE && live_q == '0) begin
							res_status_q <= dhs_pkg::ST_EMPTY_SET;
							state_q      <= S_REPLY;
						end else
							state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					kdone_q   <= kd_n;
					free_ok_q <= fok_n;
					if (!kdone_q && live_hit) begin
						found_q <= 1'b1;
						hit_q   <= h_q;
					end
					if (!free_ok_q && is_free)
						free_q <= h_q;
					if (walk_end) begin
						limit_q <= !kd_n;
						state_q <= S_WRITE;
					end else begin
						h_q     <= h_next;
						n_q     <= n_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_WRITE: begin
					res_found_q <= found_q;
					case (op_q)
						dhs_pkg::OP_ADD: begin
							if (free_ok_q)
								live_q <= live_q + 1'b1;
							else
								res_status_q <= dhs_pkg::ST_FULL;
						end
						dhs_pkg::OP_REMOVE: begin
							if (found_q)
								live_q <= live_q - 1'b1;
							else if (limit_q)
								res_status_q <= dhs_pkg::ST_FULL;
						end
						default: begin
							if (!found_q && limit_q)
								res_status_q <= dhs_pkg::ST_FULL;
						end
					endcase
					state_q <= S_REPLY;
				end
				S_REPLY: begin
					if (!out_valid_q || out_ch.ready) begin
						out_found_q  <= res_found_q;
						out_status_q <= res_status_q;
						out_count_q  <= live_q[dhs_pkg::COUNT_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/double_hash_set_engine_top.sv]
`default_nettype none
// channel   dir   fields
// in_ch     in    op[1:0], key[62:0]
// out_ch    out   found, status[1:0], count[11:0]
//
// The front reduces each key modulo both primes (three key bits a cycle), one key at a
// time, and hands the result to a two-entry queue.
// The back walks the probe path, each probe a registered slot memory read
// (S_READ) then a compare (S_CHECK), and then writes (S_WRITE) and replies (S_REPLY).
// After reset the back clears all 4093 slot marks before its first item.
// A held result stalls the back, and the front once the queue and its job register fill.
module double_hash_set_engine_top (
	input  wire logic clk,
	input  wire logic arst_n,
	dhs_in_if.sink    in_ch,
	dhs_out_if.source out_ch
);

	dhs_pkg::job_t f_job, q_job;
	logic          f_valid, f_ready, q_valid, q_ready;

	dhs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.job       (f_job),
		.job_valid (f_valid),
		.job_ready (f_ready)
	);

	dhs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_job   (f_job),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_job   (q_job),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	dhs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (q_job),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire
